// ----- rtl/c_subset_lexer_assert.svh -----
// Assertion macros shared by the lexer RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define CSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/csl_pkg.sv -----
// Shared types and constants of the C subset lexer: token codes, keyword table,
// the token record and the per-character result bundle. No dependencies.
package csl_pkg;

  localparam int MAX_TOKEN_LENGTH_DEF = 255;
  localparam int KEYWORD_CHARS_DEF    = 6;
  localparam int QUEUE_DEPTH_DEF      = 4;
  localparam int MAX_RESULTS          = 3;

  localparam logic [4:0] TK_IDENT     = 5'd0;
  localparam logic [4:0] TK_INT_LIT   = 5'd1;
  localparam logic [4:0] TK_REAL_LIT  = 5'd2;
  localparam logic [4:0] TK_FOR       = 5'd3;
  localparam logic [4:0] TK_INT       = 5'd4;
  localparam logic [4:0] TK_PLUS      = 5'd5;
  localparam logic [4:0] TK_MUL       = 5'd6;
  localparam logic [4:0] TK_REL       = 5'd7;
  localparam logic [4:0] TK_OR        = 5'd8;
  localparam logic [4:0] TK_AND       = 5'd9;
  localparam logic [4:0] TK_NOT       = 5'd10;
  localparam logic [4:0] TK_EQNE      = 5'd11;
  localparam logic [4:0] TK_SEMI      = 5'd12;
  localparam logic [4:0] TK_COMMA     = 5'd13;
  localparam logic [4:0] TK_LPAREN    = 5'd14;
  localparam logic [4:0] TK_RPAREN    = 5'd15;
  localparam logic [4:0] TK_LBRACE    = 5'd16;
  localparam logic [4:0] TK_RBRACE    = 5'd17;
  localparam logic [4:0] TK_ASSIGN    = 5'd18;
  localparam logic [4:0] TK_IF        = 5'd19;
  localparam logic [4:0] TK_WHILE     = 5'd20;
  localparam logic [4:0] TK_RETURN    = 5'd21;
  localparam logic [4:0] TK_ELSE      = 5'd22;
  localparam logic [4:0] TK_END       = 5'd23;
  localparam logic [4:0] TK_DIV       = 5'd24;
  localparam logic [4:0] TK_MINUS     = 5'd25;
  localparam logic [4:0] TK_DOT       = 5'd26;
  localparam logic [4:0] TK_MOD       = 5'd27;
  localparam logic [4:0] TK_FLOAT     = 5'd28;
  localparam logic [4:0] TK_VOID      = 5'd29;
  localparam logic [4:0] TK_DO        = 5'd30;

  typedef struct packed {
    logic [4:0] code;
    logic [7:0] len;
  } tok_t;

  // All tokens caused by one input beat, in order; cnt is 1 to 3 when queued.
  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [MAX_RESULTS-1:0] tok;
  } bundle_t;

  typedef struct packed {
    logic [47:0] text;
    logic [2:0]  len;
    logic [4:0]  code;
  } kw_t;

  localparam int KW_COUNT = 9;

  // Keyword text is written back to front so that the first character lands
  // in the low byte, matching the way the name prefix is collected.
  localparam kw_t KW_TABLE [KW_COUNT] = '{
    '{{24'h0, "tni"},    3'd3, TK_INT},
    '{{8'h0,  "taolf"},  3'd5, TK_FLOAT},
    '{{16'h0, "diov"},   3'd4, TK_VOID},
    '{{32'h0, "fi"},     3'd2, TK_IF},
    '{{8'h0,  "elihw"},  3'd5, TK_WHILE},
    '{"nruter",          3'd6, TK_RETURN},
    '{{16'h0, "esle"},   3'd4, TK_ELSE},
    '{{32'h0, "od"},     3'd2, TK_DO},
    '{{24'h0, "rof"},    3'd3, TK_FOR}
  };

endpackage

// ----- rtl/csl_front.sv -----
// Front end of the lexer: holds the scanner state and turns each accepted
// character (plus the end marker) into a bundle of tokens. Uses csl_pkg.
module csl_front #(
  parameter int MAX_TOKEN_LENGTH = csl_pkg::MAX_TOKEN_LENGTH_DEF,
  parameter int KEYWORD_CHARS    = csl_pkg::KEYWORD_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output csl_pkg::bundle_t  q_wdata
);
  import csl_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int PFX_W = 8 * KEYWORD_CHARS;

  localparam logic [3:0] ST_START = 4'd0;
  localparam logic [3:0] ST_IDENT = 4'd1;
  localparam logic [3:0] ST_INT   = 4'd2;
  localparam logic [3:0] ST_DOT   = 4'd3;
  localparam logic [3:0] ST_REAL  = 4'd4;
  localparam logic [3:0] ST_REL   = 4'd5;
  localparam logic [3:0] ST_BAR   = 4'd6;
  localparam logic [3:0] ST_AMP   = 4'd7;
  localparam logic [3:0] ST_BANG  = 4'd8;
  localparam logic [3:0] ST_EQ    = 4'd9;

  typedef struct packed {
    logic [3:0]       st;
    logic [LEN_W-1:0] len;
    logic [PFX_W-1:0] pfx;
  } scan_t;

  typedef struct packed {
    scan_t s;
    logic  hit;
    tok_t  tok;
  } start_t;

  typedef struct packed {
    scan_t      s;
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } pass_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic scan_t append(scan_t s, logic [7:0] c);
    scan_t r;
    r = s;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (s.len == LEN_W'(i)) r.pfx[8*i +: 8] = c;
    end
    if (s.len != LEN_W'(MAX_TOKEN_LENGTH)) r.len = s.len + LEN_W'(1);
    return r;
  endfunction

  function automatic logic [7:0] sat_len(logic [LEN_W-1:0] len);
    logic [LEN_W+7:0] w;
    w = {8'h0, len};
    return (w > (LEN_W + 8)'(255)) ? 8'hFF : w[7:0];
  endfunction

  function automatic logic [4:0] ident_code(scan_t s);
    logic [4:0] code;
    code = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (s.len == LEN_W'(KW_TABLE[i].len) && s.pfx == PFX_W'(KW_TABLE[i].text))
        code = KW_TABLE[i].code;
    end
    return code;
  endfunction

  function automatic start_t from_start(logic [7:0] c);
    start_t r;
    r = '0;
    r.tok.len = 8'd1;
    if (is_letter(c)) begin
      r.s    = append(r.s, c);
      r.s.st = ST_IDENT;
    end else if (is_digit(c)) begin
      r.s    = append(r.s, c);
      r.s.st = ST_INT;
    end else begin
      unique case (c) inside
        "+": begin r.hit = 1'b1; r.tok.code = TK_PLUS;   end
        "-": begin r.hit = 1'b1; r.tok.code = TK_MINUS;  end
        "*": begin r.hit = 1'b1; r.tok.code = TK_MUL;    end
        "/": begin r.hit = 1'b1; r.tok.code = TK_DIV;    end
        "%": begin r.hit = 1'b1; r.tok.code = TK_MOD;    end
        ".": begin r.hit = 1'b1; r.tok.code = TK_DOT;    end
        ";": begin r.hit = 1'b1; r.tok.code = TK_SEMI;   end
        ",": begin r.hit = 1'b1; r.tok.code = TK_COMMA;  end
        "(": begin r.hit = 1'b1; r.tok.code = TK_LPAREN; end
        ")": begin r.hit = 1'b1; r.tok.code = TK_RPAREN; end
        "{": begin r.hit = 1'b1; r.tok.code = TK_LBRACE; end
        "}": begin r.hit = 1'b1; r.tok.code = TK_RBRACE; end
        "$": begin r.hit = 1'b1; r.tok.code = TK_END;    end
        "<", ">": begin r.s = append(r.s, c); r.s.st = ST_REL;  end
        "|":      begin r.s = append(r.s, c); r.s.st = ST_BAR;  end
        "&":      begin r.s = append(r.s, c); r.s.st = ST_AMP;  end
        "!":      begin r.s = append(r.s, c); r.s.st = ST_BANG; end
        "=":      begin r.s = append(r.s, c); r.s.st = ST_EQ;   end
        default: ;
      endcase
    end
    return r;
  endfunction

  // One character through the scanner: a pending token may close (t0) and
  // the same character then restarts from the start state (t1).
  function automatic pass_t process(scan_t s, logic [7:0] c);
    pass_t      r;
    start_t     f;
    logic       flush;
    logic       pair;
    logic [7:0] second;
    logic [4:0] code1;
    logic [4:0] code2;
    r      = '0;
    r.s    = s;
    flush  = 1'b0;
    pair   = 1'b0;
    second = '0;
    code1  = '0;
    code2  = '0;
    unique case (s.st)
      ST_IDENT: begin
        if (is_letter(c) || is_digit(c)) r.s = append(s, c);
        else begin
          r.t0  = '{code: ident_code(s), len: sat_len(s.len)};
          flush = 1'b1;
        end
      end
      ST_INT: begin
        if (is_digit(c)) r.s = append(s, c);
        else if (c == ".") begin
          r.s    = append(s, c);
          r.s.st = ST_DOT;
        end else begin
          r.t0  = '{code: TK_INT_LIT, len: sat_len(s.len)};
          flush = 1'b1;
        end
      end
      ST_DOT: begin
        if (is_digit(c)) begin
          r.s    = append(s, c);
          r.s.st = ST_REAL;
        end else begin
          r.t0  = '{code: TK_END, len: sat_len(s.len)};
          flush = 1'b1;
        end
      end
      ST_REAL: begin
        if (is_digit(c)) r.s = append(s, c);
        else begin
          r.t0  = '{code: TK_REAL_LIT, len: sat_len(s.len)};
          flush = 1'b1;
        end
      end
      ST_REL:  begin pair = 1'b1; second = "="; code1 = TK_REL;    code2 = TK_REL;  end
      ST_BAR:  begin pair = 1'b1; second = "|"; code1 = TK_END;    code2 = TK_OR;   end
      ST_AMP:  begin pair = 1'b1; second = "&"; code1 = TK_END;    code2 = TK_AND;  end
      ST_BANG: begin pair = 1'b1; second = "="; code1 = TK_NOT;    code2 = TK_EQNE; end
      ST_EQ:   begin pair = 1'b1; second = "="; code1 = TK_ASSIGN; code2 = TK_EQNE; end
      default: begin
        f    = from_start(c);
        r.s  = f.s;
        r.t0 = f.tok;
        r.n  = {1'b0, f.hit};
      end
    endcase
    if (pair) begin
      if (c == second) begin
        r.t0 = '{code: code2, len: 8'd2};
        r.s  = '0;
        r.n  = 2'd1;
      end else begin
        r.t0  = '{code: code1, len: 8'd1};
        flush = 1'b1;
      end
    end
    if (flush) begin
      f    = from_start(c);
      r.s  = f.s;
      r.t1 = f.tok;
      r.n  = f.hit ? 2'd2 : 2'd1;
    end
    return r;
  endfunction

  scan_t   scan_r;
  scan_t   scan_nxt;
  pass_t   p1;
  pass_t   p2;
  bundle_t bun;
  logic    accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    p1  = process(scan_r, in_tdata);
    p2  = process(p1.s, "$");
    bun = '0;
    bun.tok[0] = p1.t0;
    bun.tok[1] = p1.t1;
    bun.cnt    = p1.n;
    if (in_tlast) begin
      bun.cnt = p1.n + p2.n;
      case (p1.n)
        2'd0: begin
          bun.tok[0] = p2.t0;
          bun.tok[1] = p2.t1;
        end
        2'd1: begin
          bun.tok[1] = p2.t0;
          bun.tok[2] = p2.t1;
        end
        default: bun.tok[2] = p2.t0;
      endcase
    end
    scan_nxt = in_tlast ? p2.s : p1.s;
  end

  assign q_push  = accept && (bun.cnt != 2'd0);
  assign q_wdata = bun;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (accept) begin
      scan_r <= scan_nxt;
    end
  end

endmodule

// ----- rtl/csl_queue.sv -----
// Short queue of token bundles between the lexer front and back ends.
// Uses csl_pkg for the bundle type and the shared assertion macros.
`include "c_subset_lexer_assert.svh"

module csl_queue #(
  parameter int DEPTH = csl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  csl_pkg::bundle_t  wdata,
  input  logic              pop,
  output csl_pkg::bundle_t  rdata,
  output logic              q_valid,
  output logic              q_full
);
  import csl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign rdata   = mem[rd_ptr_r];
  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  `CSL_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_full || pop, "queue written while full")
  `CSL_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, q_valid, "queue read while empty")
  `CSL_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue count past depth")

endmodule

// ----- rtl/csl_back.sv -----
// Back end of the lexer: walks the bundle at the queue head and sends one
// token per output beat through a registered output stage. Uses csl_pkg.
`include "c_subset_lexer_assert.svh"

module csl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  csl_pkg::bundle_t  q_rdata,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // token_code [4:0], token_length [12:5], zero
  output logic              out_tlast    // last_of_run
);
  import csl_pkg::*;

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       out_valid_r;
  tok_t       out_tok_r;
  logic       out_last_r;
  logic       load;
  logic       final_tok;

  assign load      = q_valid && (!out_valid_r || out_tready);
  assign final_tok = (idx_r + 2'd1 == q_rdata.cnt);
  assign q_pop     = load && final_tok;
  assign idx_nxt   = final_tok ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= q_rdata.tok[idx_r];
      out_last_r <= final_tok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_tok_r.len, out_tok_r.code};
  assign out_tlast  = out_last_r;

  `CSL_ASSERT_IMP(a_bundle_nonempty, clk, rst_n, q_valid, q_rdata.cnt != 2'd0, "empty bundle queued")
  `CSL_ASSERT_IMP(a_idx_in_range, clk, rst_n, q_valid, idx_r < q_rdata.cnt, "token index past bundle")
  `CSL_ASSERT_NXT(a_idx_restart, clk, rst_n, q_pop, idx_r == 2'd0, "index not cleared after bundle")

endmodule

// ----- rtl/c_subset_lexer.sv -----
// Lexer top level. The character completing a token pushes its bundle into the queue,
// whose head feeds the registered output stage; one character is taken per cycle
// while the queue is not full. A character that causes n tokens yields n output
// beats, and a queue of QUEUE_DEPTH bundles absorbs bursts before in_tready drops.
// Synchronous active-low reset returns the scanner to its start state and
// empties the queue and output stage; the block is usable the next cycle.
module c_subset_lexer #(
  parameter int MAX_TOKEN_LENGTH = csl_pkg::MAX_TOKEN_LENGTH_DEF,
  parameter int KEYWORD_CHARS    = csl_pkg::KEYWORD_CHARS_DEF,
  parameter int QUEUE_DEPTH      = csl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // char_in [7:0]
  input  logic        in_tlast,    // end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // token_code [4:0], token_length [12:5], zero
  output logic        out_tlast    // last_of_run
);
  import csl_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  logic    q_full;
  bundle_t q_wdata;
  bundle_t q_rdata;

  csl_front #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .KEYWORD_CHARS    (KEYWORD_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  csl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .rdata   (q_rdata),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  csl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- bench/lexer_token_checker.sv -----
// Token checker for the C subset lexer: watches both stream channels, predicts the tokens
// that each character beat causes and compares them with the output beats.
// Depends on csl_pkg for the token codes and result limits.
module lexer_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // char_in [7:0]
  input  logic        in_tlast,    // end_of_source
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // token_code [4:0], token_length [12:5], zero
  input  logic        out_tlast,   // last_of_run
  output int          mismatches,
  output int          tokens_pending
);
  import csl_pkg::*;

  typedef enum logic [3:0] {
    SCAN_START, SCAN_IDENT, SCAN_INT, SCAN_DOT, SCAN_REAL,
    SCAN_REL, SCAN_BAR, SCAN_AMP, SCAN_BANG, SCAN_EQ
  } scan_e;

  typedef struct packed {
    logic [4:0] code;
    logic [7:0] len;
    logic       last;
  } token_t;

  scan_e       scan;
  int unsigned lex_len;
  logic [47:0] name_head;
  token_t      tokens_due[$];
  token_t      beat_toks[MAX_RESULTS];
  int          beat_cnt;
  int          fail_total = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: token mismatch: %s", $time, msg);
    fail_total++;
  endtask

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword text is held back to front: the first character sits in the low byte.
  function automatic logic [4:0] name_code();
    case (lex_len)
      2: begin
        if (name_head == {32'h0, "fi"}) return TK_IF;
        if (name_head == {32'h0, "od"}) return TK_DO;
      end
      3: begin
        if (name_head == {24'h0, "tni"}) return TK_INT;
        if (name_head == {24'h0, "rof"}) return TK_FOR;
      end
      4: begin
        if (name_head == {16'h0, "diov"}) return TK_VOID;
        if (name_head == {16'h0, "esle"}) return TK_ELSE;
      end
      5: begin
        if (name_head == {8'h0, "taolf"}) return TK_FLOAT;
        if (name_head == {8'h0, "elihw"}) return TK_WHILE;
      end
      6: begin
        if (name_head == "nruter") return TK_RETURN;
      end
      default: ;
    endcase
    return TK_IDENT;
  endfunction

  task automatic emit_token(input logic [4:0] code, input int unsigned len);
    if (beat_cnt < MAX_RESULTS) begin
      beat_toks[beat_cnt].code = code;
      beat_toks[beat_cnt].len  = (len > 255) ? 8'd255 : len[7:0];
      beat_toks[beat_cnt].last = 1'b0;
      beat_cnt++;
      scan      = SCAN_START;
      lex_len   = 0;
      name_head = '0;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    if (lex_len < KEYWORD_CHARS_DEF) name_head[8*lex_len +: 8] = c;
    if (lex_len < MAX_TOKEN_LENGTH_DEF) lex_len++;
  endtask

  task automatic start_char(input logic [7:0] c);
    lex_len   = 0;
    name_head = '0;
    scan      = SCAN_START;
    if (is_letter(c)) begin
      scan = SCAN_IDENT;
      take_char(c);
    end else if (is_digit(c)) begin
      scan = SCAN_INT;
      take_char(c);
    end else begin
      case (c)
        "+": emit_token(TK_PLUS, 1);
        "-": emit_token(TK_MINUS, 1);
        "*": emit_token(TK_MUL, 1);
        "/": emit_token(TK_DIV, 1);
        "%": emit_token(TK_MOD, 1);
        ".": emit_token(TK_DOT, 1);
        ";": emit_token(TK_SEMI, 1);
        ",": emit_token(TK_COMMA, 1);
        "(": emit_token(TK_LPAREN, 1);
        ")": emit_token(TK_RPAREN, 1);
        "{": emit_token(TK_LBRACE, 1);
        "}": emit_token(TK_RBRACE, 1);
        "$": emit_token(TK_END, 1);
        "<", ">": begin
          scan = SCAN_REL;
          take_char(c);
        end
        "|": begin
          scan = SCAN_BAR;
          take_char(c);
        end
        "&": begin
          scan = SCAN_AMP;
          take_char(c);
        end
        "!": begin
          scan = SCAN_BANG;
          take_char(c);
        end
        "=": begin
          scan = SCAN_EQ;
          take_char(c);
        end
        default: ;
      endcase
    end
  endtask

  // Second character of a two-character operator, or the end of a single one.
  task automatic pair_char(input logic [7:0] c, input logic [7:0] second,
                           input logic [4:0] single_code, input logic [4:0] double_code);
    if (c == second) begin
      emit_token(double_code, 2);
    end else begin
      emit_token(single_code, 1);
      start_char(c);
    end
  endtask

  task automatic step_char(input logic [7:0] c);
    case (scan)
      SCAN_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          take_char(c);
        end else begin
          emit_token(name_code(), lex_len);
          start_char(c);
        end
      end
      SCAN_INT: begin
        if (is_digit(c)) begin
          take_char(c);
        end else if (c == ".") begin
          scan = SCAN_DOT;
          take_char(c);
        end else begin
          emit_token(TK_INT_LIT, lex_len);
          start_char(c);
        end
      end
      SCAN_DOT: begin
        if (is_digit(c)) begin
          scan = SCAN_REAL;
          take_char(c);
        end else begin
          // Digits and a dot with no fraction are malformed.
          emit_token(TK_END, lex_len);
          start_char(c);
        end
      end
      SCAN_REAL: begin
        if (is_digit(c)) begin
          take_char(c);
        end else begin
          emit_token(TK_REAL_LIT, lex_len);
          start_char(c);
        end
      end
      SCAN_REL:  pair_char(c, "=", TK_REL, TK_REL);
      SCAN_BAR:  pair_char(c, "|", TK_END, TK_OR);
      SCAN_AMP:  pair_char(c, "&", TK_END, TK_AND);
      SCAN_BANG: pair_char(c, "=", TK_NOT, TK_EQNE);
      SCAN_EQ:   pair_char(c, "=", TK_ASSIGN, TK_EQNE);
      default:   start_char(c);
    endcase
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    logic [4:0] got_code;
    logic [7:0] got_len;
    if (!rst_n) begin
      scan      = SCAN_START;
      lex_len   = 0;
      name_head = '0;
      tokens_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        beat_cnt = 0;
        step_char(in_tdata);
        if (in_tlast) step_char("$");
        for (int i = 0; i < beat_cnt; i++) begin
          want      = beat_toks[i];
          want.last = (i == beat_cnt - 1);
          tokens_due.push_back(want);
        end
      end
      if (out_tvalid && out_tready) begin
        got_code = out_tdata[4:0];
        got_len  = out_tdata[12:5];
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("token code %0d length %0d with none expected",
                                    got_code, got_len));
        end else begin
          want = tokens_due.pop_front();
          if (got_code != want.code)
            report_mismatch($sformatf("code %0d, expected %0d", got_code, want.code));
          if (got_len != want.len)
            report_mismatch($sformatf("length %0d, expected %0d (code %0d)",
                                      got_len, want.len, want.code));
          if (out_tlast != want.last)
            report_mismatch($sformatf("last %0b, expected %0b (code %0d)",
                                      out_tlast, want.last, want.code));
          if (out_tdata[15:13] != 3'b000)
            report_mismatch($sformatf("padding bits %b, expected zero", out_tdata[15:13]));
        end
      end
    end
    mismatches     <= fail_total;
    tokens_pending <= tokens_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// Top of the lexer testbench: clock, reset, character stimulus, receiver stalls and verdict.
// Depends on c_subset_lexer (with csl_pkg) and on lexer_token_checker for prediction.
module tb;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASE_CHARS  = 32;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        hold_arm       = 1'b0;
  logic        hold_used      = 1'b0;
  int          quiet_cycles   = 0;
  logic [7:0]  src_chars[$];

  string kw_list[9]   = '{"int", "float", "void", "if", "while", "return", "else", "do", "for"};
  string pair_ops[6]  = '{"<=", ">=", "||", "&&", "==", "!="};
  string single_ops   = "+-*/%.;,(){}=!<>|&$";
  string name_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string blanks       = " \t\n\r";
  int    idle_tab[4]  = '{0, 74, 0, 12};
  int    stall_tab[4] = '{0, 0, 74, 12};

  c_subset_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lexer_token_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatches     (fail_count),
    .tokens_pending (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that lets the lexer back up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("** c_subset_lexer: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // A character that completes no token may still be inside the lexer.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_name_char(input logic leading);
    return name_chars[$urandom_range(0, leading ? 52 : name_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // One lexeme-shaped run of characters, mostly well formed, sometimes noise.
  task automatic make_fragment();
    int    pick;
    int    n;
    string word;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      word = kw_list[$urandom_range(0, 8)];
      for (int i = 0; i < word.len(); i++) src_chars.push_back(word[i]);
      if ($urandom_range(0, 2) == 0) src_chars.push_back(pick_name_char(1'b0));
    end else if (pick < 33) begin
      n = $urandom_range(1, 9);
      src_chars.push_back(pick_name_char(1'b1));
      for (int i = 1; i < n; i++) src_chars.push_back(pick_name_char(1'b0));
    end else if (pick < 47) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) src_chars.push_back(pick_digit());
    end else if (pick < 56) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) src_chars.push_back(pick_digit());
      src_chars.push_back(".");
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) src_chars.push_back(pick_digit());
    end else if (pick < 61) begin
      // A digit and a dot; whatever comes next decides between real and malformed.
      src_chars.push_back(pick_digit());
      src_chars.push_back(".");
    end else if (pick < 78) begin
      src_chars.push_back(single_ops[$urandom_range(0, single_ops.len() - 1)]);
    end else if (pick < 90) begin
      word = pair_ops[$urandom_range(0, 5)];
      src_chars.push_back(word[0]);
      src_chars.push_back(word[1]);
    end else begin
      src_chars.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0)
      src_chars.push_back(blanks[$urandom_range(0, blanks.len() - 1)]);
  endtask

  task automatic run_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if (src_chars.size() == 0) make_fragment();
      send_char(src_chars.pop_front(), $urandom_range(0, 99) < 4);
      sent++;
    end
    src_chars.delete();
  endtask

  initial begin : stimulus
    string directed;
    directed = "do 1.5<=x||y&1.;$[";
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: keyword, real, dangling dot, lone ampersand, literal end marker,
    // skipped bytes at both extremes, and three tokens from one beat.
    for (int i = 0; i < directed.len(); i++) send_char(directed[i], 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("!", 1'b0);
    send_char("a", 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) begin
        // Token-rich characters while the receiver holds off, so the queue fills.
        hold_arm = 1'b1;
        run_random(PHASE_CHARS);
        // Long identifier to saturate the length.
        src_chars.push_back("L");
        for (int i = 0; i < 269; i++) src_chars.push_back(pick_name_char(1'b0));
        src_chars.push_back(" ");
        run_random(271);
      end else begin
        run_random(PHASE_CHARS);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("** c_subset_lexer: PASSED **");
    end else begin
      $display("** c_subset_lexer: FAILED **");
    end
    $finish;
  end

endmodule
